@@ rtl/core/stereo_state_variable_filter_core_macros.svh @@
// Assertion macros shared by the stereo state variable filter checkers.
`ifndef STEREO_STATE_VARIABLE_FILTER_CORE_MACROS_SVH
`define STEREO_STATE_VARIABLE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssvf check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssvf check failed");

`endif

@@ rtl/core/ssvf_pkg.sv @@
// Types, widths, states and saturation helpers of the stereo state variable filter.
package ssvf_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int CHANNELS_DEF = 2;
  localparam int COEF_W       = 24;
  localparam int DAMP_W       = 22;
  localparam int COEF_FRAC    = 20;
  localparam int STATE_W      = 32;
  localparam int DEN_W        = 30;
  localparam int NUM_W        = 59;
  localparam int MAG_W        = 58;
  localparam int DIV_CNT_W    = $clog2(MAG_W);
  localparam int MUL_A_W      = 26;
  localparam int MUL_B_W      = 33;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int BP_W         = 37;
  localparam int BP_LO_W      = 16;
  localparam int BP_HI_W      = BP_W - BP_LO_W;
  localparam int WIDE_W       = 64;
  localparam int V2_W         = WIDE_W - COEF_FRAC;

  localparam logic signed [WIDE_W-1:0] STATE_MAX_W =
    (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] STATE_MIN_W = -(64'sd1 <<< (STATE_W - 1));
  localparam logic signed [WIDE_W-1:0] SMP_MAX_W =
    (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] SMP_MIN_W = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

  localparam logic filter_mode_lowpass  = 1'b0;
  localparam logic filter_mode_highpass = 1'b1;

  typedef struct packed {
    logic                           channel;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [COEF_W-1:0]              cutoff_coef;
    logic [DAMP_W-1:0]              damping;
  } ssvf_in_t;

  typedef struct packed {
    logic                           channel_out;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           states_neutral;
  } ssvf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KG,
    ST_GG,
    ST_DEN,
    ST_NUM,
    ST_DIV,
    ST_QUO,
    ST_GH,
    ST_V1,
    ST_BPL,
    ST_BPH,
    ST_V2,
    ST_LP,
    ST_WB
  } ssvf_state_t;

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [WIDE_W-1:0] v
  );
    if (v > STATE_MAX_W) begin
      return STATE_MAX_W[STATE_W-1:0];
    end else if (v < STATE_MIN_W) begin
      return STATE_MIN_W[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [WIDE_W-1:0] v
  );
    if (v > SMP_MAX_W) begin
      return SMP_MAX_W[SAMPLE_WIDTH-1:0];
    end else if (v < SMP_MIN_W) begin
      return SMP_MIN_W[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/core/stereo_state_variable_filter_core.sv @@
// Top level of the stereo zero-delay-feedback state variable filter.
// Filters one request at a time: each accepted sample passes from acceptance to
// the result register through an accept step, four multiply steps that build the
// denominator and numerator, the restoring divider that produces one quotient bit
// a cycle, and eight steps that update the integrators and pick the output. The
// one 26x33-bit signed multiplier is shared by all six products. The result
// waits in an output register, so the next request is taken as soon as the
// sequencer is back in idle, even if the previous result has not been drained.
// filter_mode (cfg_wr_en/cfg_wr_data) selects lowpass (0) or highpass (1) and
// is meant to be written while idle.
module stereo_state_variable_filter_core
  import ssvf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ssvf_in_t  in_payload,
  output logic      out_valid,
  input  logic      out_ready,
  output ssvf_out_t out_payload,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << COEF_FRAC;

  ssvf_state_t state_r, state_nxt;

  logic                           filter_mode_r;
  logic signed [STATE_W-1:0]      band_mem_r [CHANNELS];
  logic signed [STATE_W-1:0]      low_mem_r  [CHANNELS];

  logic                           ch_r;
  logic [CH_W-1:0]                idx_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [COEF_W-1:0]              g_r;
  logic [DAMP_W-1:0]              k_r;
  logic signed [STATE_W-1:0]      s1_r;
  logic signed [STATE_W-1:0]      s2_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [PROD_W-1:0]       acc_r;
  logic [DEN_W-1:0]               den_r;
  logic                           neg_r;
  logic [MAG_W-1:0]               q_r;
  logic [DEN_W-1:0]               rem_r;
  logic [DIV_CNT_W-1:0]           cnt_r;
  logic signed [STATE_W-1:0]      h_r;
  logic signed [BP_W-1:0]         bp_r;
  logic signed [STATE_W-1:0]      s1n_r;
  logic signed [V2_W-1:0]         v2_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic                           out_valid_r;
  ssvf_out_t                      out_r;

  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic [COEF_W:0]                kpg;
  logic [CH_W-1:0]                in_idx;
  logic                           in_acc;
  logic                           out_free;

  logic [PROD_W-1:0]              den_sum;
  logic signed [NUM_W-1:0]        num_w;
  logic signed [NUM_W-1:0]        num_abs;
  logic [DEN_W:0]                 rem_sh;
  logic                           quo_bit;
  logic signed [STATE_W-1:0]      h_sat;
  logic signed [WIDE_W-1:0]       v1_w;
  logic signed [WIDE_W-1:0]       bp_w;
  logic signed [WIDE_W-1:0]       full_w;
  logic signed [WIDE_W-1:0]       v2_w;
  logic signed [WIDE_W-1:0]       lp_w;
  logic                           neutral;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;
  assign in_idx      = (CHANNELS > 1) ? CH_W'(in_payload.channel) : '0;
  assign kpg         = {1'b0, g_r} + (COEF_W + 1)'(k_r);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and operand selection for the shared multiplier.
  always_comb begin
    state_nxt = state_r;
    mul_a     = $signed({2'b00, g_r});
    mul_b     = $signed({(MUL_B_W - COEF_W)'(0), g_r});
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_KG;
        end
      end
      ST_KG: begin
        mul_b     = $signed({(MUL_B_W - DAMP_W)'(0), k_r});
        state_nxt = ST_GG;
      end
      ST_GG: begin
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        mul_a     = $signed({1'b0, kpg});
        mul_b     = MUL_B_W'(s1_r);
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_QUO;
        end
      end
      ST_QUO: begin
        state_nxt = ST_GH;
      end
      ST_GH: begin
        mul_b     = MUL_B_W'(h_r);
        state_nxt = ST_V1;
      end
      ST_V1: begin
        state_nxt = ST_BPL;
      end
      ST_BPL: begin
        mul_b     = $signed({(MUL_B_W - BP_LO_W)'(0), bp_r[BP_LO_W-1:0]});
        state_nxt = ST_BPH;
      end
      ST_BPH: begin
        mul_b     = MUL_B_W'($signed(bp_r[BP_W-1:BP_LO_W]));
        state_nxt = ST_V2;
      end
      ST_V2: begin
        state_nxt = ST_LP;
      end
      ST_LP: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath arithmetic around the registered product.
  always_comb begin
    den_sum = acc_r + prod_r;
    num_w   = (NUM_W'(x_r) <<< COEF_FRAC) - NUM_W'(prod_r) - (NUM_W'(s2_r) <<< COEF_FRAC);
    num_abs = num_w[NUM_W-1] ? -num_w : num_w;
    rem_sh  = {rem_r, q_r[MAG_W-1]};
    quo_bit = (rem_sh >= {1'b0, den_r});
    // Truncated quotient magnitude, then sign and clamp to the state range.
    if (!neg_r) begin
      h_sat = (|q_r[MAG_W-1:STATE_W-1]) ? STATE_MAX_W[STATE_W-1:0]
                                        : $signed(q_r[STATE_W-1:0]);
    end else if (|q_r[MAG_W-1:STATE_W] || (q_r[STATE_W-1] && |q_r[STATE_W-2:0])) begin
      h_sat = STATE_MIN_W[STATE_W-1:0];
    end else begin
      h_sat = $signed(-q_r[STATE_W-1:0]);
    end
    v1_w   = WIDE_W'($signed(prod_r[PROD_W-1:COEF_FRAC]));
    bp_w   = v1_w + WIDE_W'(s1_r);
    full_w = (WIDE_W'(prod_r) <<< BP_LO_W) + WIDE_W'(acc_r);
    v2_w   = WIDE_W'(v2_r);
    lp_w   = v2_w + WIDE_W'(s2_r);
    neutral = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (band_mem_r[i] != '0 || low_mem_r[i] != '0) begin
        neutral = 1'b0;
      end
    end
  end

  // Shared multiplier, registered before any use of its product.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Operand capture, division and integrator update steps.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_r  <= in_payload.channel;
          idx_r <= in_idx;
          x_r   <= in_payload.sample_in;
          g_r   <= in_payload.cutoff_coef;
          k_r   <= in_payload.damping;
          s1_r  <= band_mem_r[in_idx];
          s2_r  <= low_mem_r[in_idx];
        end
      end
      ST_GG: begin
        acc_r <= prod_r;
      end
      ST_DEN: begin
        den_r <= den_sum[COEF_FRAC +: DEN_W] + DEN_ONE;
      end
      ST_NUM: begin
        neg_r <= num_w[NUM_W-1];
        q_r   <= num_abs[MAG_W-1:0];
        rem_r <= '0;
        cnt_r <= DIV_CNT_W'(MAG_W - 1);
      end
      ST_DIV: begin
        // Shift in one dividend bit, subtract when the divisor fits.
        rem_r <= quo_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        q_r   <= {q_r[MAG_W-2:0], quo_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_QUO: begin
        h_r <= h_sat;
      end
      ST_V1: begin
        bp_r  <= bp_w[BP_W-1:0];
        s1n_r <= sat_state(bp_w + v1_w);
      end
      ST_BPH: begin
        acc_r <= prod_r;
      end
      ST_V2: begin
        v2_r <= full_w[WIDE_W-1:COEF_FRAC];
      end
      ST_LP: begin
        y_r <= sat_sample((filter_mode_r == filter_mode_highpass) ? WIDE_W'(h_r) : lp_w);
      end
      default: begin
      end
    endcase
  end

  // Integrator state, mode register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= filter_mode_lowpass;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        band_mem_r[i] <= '0;
        low_mem_r[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        filter_mode_r <= cfg_wr_data;
      end
      if (state_r == ST_LP) begin
        band_mem_r[idx_r] <= s1n_r;
        low_mem_r[idx_r]  <= sat_state(lp_w + v2_w);
      end
      if (state_r == ST_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WB && out_free) begin
      out_r.channel_out    <= ch_r;
      out_r.sample_out     <= y_r;
      out_r.states_neutral <= neutral;
    end
  end

endmodule

@@ rtl/core/ssvf_checker.sv @@
// Port-level checks of the stereo state variable filter core and their bind.
`include "stereo_state_variable_filter_core_macros.svh"

module ssvf_checker
  import ssvf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input ssvf_out_t out_payload
);

  // A request keeps the core busy on the following cycle.
  `SSVF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A new result shows up only as the sequencer returns to idle.
  `SSVF_ASSERT_IMP(a_result_with_idle, $rose(out_valid), in_ready)
  // Hold a stalled result.
  `SSVF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SSVF_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))

endmodule

bind stereo_state_variable_filter_core ssvf_checker u_ssvf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);
